// ===== hw/rtl/rnea_pkg.sv =====
package rnea_pkg;

    localparam int MASK_W = 9;

    localparam logic [1:0] ST_THINKING = 2'd0;
    localparam logic [1:0] ST_HUNGRY   = 2'd1;
    localparam logic [1:0] ST_EATING   = 2'd2;
    localparam logic [1:0] ST_GONE     = 2'd3;

    localparam logic [1:0] OP_REQUEST = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_ADD     = 2'd2;
    localparam logic [1:0] OP_REMOVE  = 2'd3;

    localparam logic [1:0] STS_DONE     = 2'd0;
    localparam logic [1:0] STS_LIMIT    = 2'd1;
    localparam logic [1:0] STS_INACTIVE = 2'd2;
    localparam logic [1:0] STS_BUSY     = 2'd3;

    localparam logic CFG_MIN_SEATS = 1'b0;
    localparam logic CFG_MAX_SEATS = 1'b1;

    localparam logic [3:0] MIN_SEATS_RST = 4'd4;
    localparam logic [3:0] MAX_SEATS_RST = 4'd9;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] seat;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [MASK_W-1:0] granted_mask;
        logic [MASK_W-1:0] eating_mask;
        logic [3:0]        active_count;
    } t_out;

    typedef struct packed {
        logic latch;
        logic exec;
        logic right;
        logic load;
    } t_cmd;

    typedef struct packed {
        logic release_go;
        logic out_free;
    } t_sts;

endpackage

// ===== hw/rtl/rnea_ctrl.sv =====
module rnea_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  rnea_pkg::t_sts i_sts,
    output rnea_pkg::t_cmd o_cmd,
    output logic           o_in_stall
);
    import rnea_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EXEC  = 2'd1;
    localparam logic [1:0] S_RIGHT = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.release_go ? S_RIGHT : S_DONE;
            end
            S_RIGHT: begin
                o_cmd.right = 1'b1;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/rnea_dp.sv =====
module rnea_dp #(
    parameter int SEATS = 9
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rnea_pkg::t_cmd i_cmd,
    output rnea_pkg::t_sts o_sts,
    input  rnea_pkg::t_in  i_in_data,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_index,
    input  logic [3:0]     i_cfg_data,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output rnea_pkg::t_out o_out_data
);
    import rnea_pkg::*;

    localparam int IW = $clog2(SEATS);
    localparam int TW = $clog2(SEATS + 1);
    localparam int CW = (TW > 4) ? TW : 4;

    logic [1:0]        r_stat [SEATS];
    logic [1:0]        n_stat [SEATS];
    logic [TW-1:0]     r_total;
    logic [TW-1:0]     n_total;
    logic [3:0]        r_min;
    logic [3:0]        r_max;
    t_in               r_in;
    logic [1:0]        r_res;
    logic [1:0]        n_res;
    logic [MASK_W-1:0] r_grant;
    logic [MASK_W-1:0] n_grant;
    logic              r_out_valid;
    t_out              r_out;
    logic [MASK_W-1:0] eat_mask;

    logic          seat_ok;
    logic [IW-1:0] s;
    logic [IW-1:0] sl;
    logic [IW-1:0] sr;
    logic [IW-1:0] sll;
    logic [IW-1:0] srl;
    logic [IW-1:0] srr;

    function automatic logic [IW-1:0] left_of(input logic [IW-1:0] x,
                                              input logic [TW-1:0] t);
        logic [TW-1:0] tm;
        tm = t - 1'b1;
        return (x == '0) ? tm[IW-1:0] : x - 1'b1;
    endfunction

    function automatic logic [IW-1:0] right_of(input logic [IW-1:0] x,
                                               input logic [TW-1:0] t);
        logic [TW-1:0] xp;
        xp = TW'(x) + 1'b1;
        return (xp == t) ? '0 : xp[IW-1:0];
    endfunction

    function automatic logic [MASK_W-1:0] seat_bit(input logic [IW-1:0] x);
        logic [MASK_W-1:0] b;
        b = '0;
        for (int i = 0; i < MASK_W; i++) begin
            b[i] = (int'(x) == i);
        end
        return b;
    endfunction

    assign s       = r_in.seat[IW-1:0];
    assign seat_ok = CW'(r_in.seat) < CW'(r_total);
    assign sl      = left_of(s, r_total);
    assign sr      = right_of(s, r_total);
    assign sll     = left_of(sl, r_total);
    assign srl     = left_of(sr, r_total);
    assign srr     = right_of(sr, r_total);

    assign o_sts.release_go = (r_in.opcode == OP_RELEASE) && seat_ok;
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    for (genvar g = 0; g < MASK_W; g++) begin : g_eat
        if (g < SEATS) begin : g_on
            assign eat_mask[g] = (r_stat[g] == ST_EATING);
        end else begin : g_off
            assign eat_mask[g] = 1'b0;
        end
    end

    always_comb begin
        n_stat  = r_stat;
        n_total = r_total;
        n_res   = r_res;
        n_grant = r_grant;
        if (i_cmd.latch) begin
            n_res   = STS_DONE;
            n_grant = '0;
        end
        if (i_cmd.exec) begin
            case (r_in.opcode)
                OP_REQUEST: begin
                    if (!seat_ok) begin
                        n_res = STS_INACTIVE;
                    end else if (r_stat[s] != ST_THINKING) begin
                        n_res = STS_BUSY;
                    end else if (r_stat[sl] != ST_EATING && r_stat[sr] != ST_EATING) begin
                        n_stat[s] = ST_EATING;
                        n_grant   = seat_bit(s);
                    end else begin
                        n_stat[s] = ST_HUNGRY;
                    end
                end
                OP_RELEASE: begin
                    if (!seat_ok) begin
                        n_res = STS_INACTIVE;
                    end else begin
                        n_stat[s] = ST_THINKING;
                        // left neighbor: its right side is the seat just freed
                        if (sl != s && r_stat[sl] == ST_HUNGRY &&
                            (sll == s || r_stat[sll] != ST_EATING)) begin
                            n_stat[sl] = ST_EATING;
                            n_grant    = seat_bit(sl);
                        end
                    end
                end
                OP_ADD: begin
                    if (CW'(r_total) >= CW'(r_max) || r_total >= TW'(SEATS)) begin
                        n_res = STS_LIMIT;
                    end else begin
                        n_stat[r_total[IW-1:0]] = ST_THINKING;
                        n_total                 = r_total + 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (CW'(r_total) <= CW'(r_min) || r_total == '0) begin
                        n_res = STS_LIMIT;
                    end else begin
                        n_total                 = r_total - 1'b1;
                        n_stat[n_total[IW-1:0]] = ST_GONE;
                    end
                end
                default: n_res = r_res;
            endcase
        end
        if (i_cmd.right) begin
            if (r_stat[sr] == ST_HUNGRY && r_stat[srl] != ST_EATING &&
                r_stat[srr] != ST_EATING) begin
                n_stat[sr] = ST_EATING;
                n_grant    = r_grant | seat_bit(sr);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SEATS; i++) begin
                r_stat[i] <= ST_GONE;
            end
            r_total     <= '0;
            r_min       <= MIN_SEATS_RST;
            r_max       <= MAX_SEATS_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_stat  <= n_stat;
            r_total <= n_total;
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_MIN_SEATS) begin
                    r_min <= i_cfg_data;
                end else begin
                    r_max <= i_cfg_data;
                end
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_in <= i_in_data;
        end
        r_res   <= n_res;
        r_grant <= n_grant;
        if (i_cmd.load) begin
            r_out.status       <= r_res;
            r_out.granted_mask <= r_grant;
            r_out.eating_mask  <= eat_mask;
            r_out.active_count <= 4'(r_total);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hw/rtl/ring_neighbor_exclusion_arbiter.sv =====
// Flow: the input beat is latched, then the operation executes; a release of an active
// seat tests the left and right neighbors in turn. The result waits for a free output register;
// the controller holds the input stalled until the result is in the output register,
// so a new beat is not accepted while one is in progress.
// Reset (synchronous, active low): all seats gone, count zero,
// min_seats 4, max_seats 9, no result pending.
module ring_neighbor_exclusion_arbiter #(
    parameter int SEATS = 9
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  rnea_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output rnea_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic           i_cfg_index,
    input  logic [3:0]     i_cfg_data
);
    import rnea_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    rnea_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    rnea_dp #(
        .SEATS (SEATS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== bench/tb_ring_neighbor_exclusion_arbiter.sv =====
module tb_ring_neighbor_exclusion_arbiter;
    timeunit 1ns;
    timeprecision 1ps;

    import rnea_pkg::*;

    localparam int SEATS = 9;
    localparam int PHASE_BEATS = 170;
    localparam int NUM_PHASES = 7;

    typedef struct packed {
        t_in  beat;
        logic typed;
        t_out res;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out_data;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic i_cfg_index;
    logic [3:0] i_cfg_data;

    // mirror of the arbiter state
    logic [1:0]  seat_st [SEATS];
    int unsigned seat_cnt;
    logic [3:0]  min_lim;
    logic [3:0]  max_lim;

    t_out      pending[$];
    t_plan_row plan[$];
    int        n_err = 0;
    logic      calm = 1'b0;

    logic [3:0] lo_set [NUM_PHASES] = '{4'd4, 4'd2, 4'd9, 4'd2, 4'd0, 4'd5, 4'd3};
    logic [3:0] hi_set [NUM_PHASES] = '{4'd9, 4'd3, 4'd9, 4'd9, 4'd15, 4'd6, 4'd9};

    ring_neighbor_exclusion_arbiter #(.SEATS(SEATS)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #400us;
        $display("simulation failed");
        $finish;
    end

    function automatic int unsigned left_seat(int unsigned s);
        return (s + seat_cnt - 1) % seat_cnt;
    endfunction

    function automatic int unsigned right_seat(int unsigned s);
        return (s + 1) % seat_cnt;
    endfunction

    function automatic logic [MASK_W-1:0] try_seat(int unsigned s);
        logic [MASK_W-1:0] bitmask;
        bitmask = '0;
        if (seat_st[s] == ST_HUNGRY && seat_st[left_seat(s)] != ST_EATING &&
                seat_st[right_seat(s)] != ST_EATING) begin
            seat_st[s] = ST_EATING;
            bitmask[s] = 1'b1;
        end
        return bitmask;
    endfunction

    function automatic t_out arbitrate(t_in beat);
        t_out r;
        r = '0;
        r.status = STS_DONE;
        case (beat.opcode)
            OP_REQUEST, OP_RELEASE: begin
                if (beat.seat >= seat_cnt) begin
                    r.status = STS_INACTIVE;
                end else if (beat.opcode == OP_REQUEST) begin
                    if (seat_st[beat.seat] != ST_THINKING) begin
                        r.status = STS_BUSY;
                    end else begin
                        seat_st[beat.seat] = ST_HUNGRY;
                        r.granted_mask = try_seat(beat.seat);
                    end
                end else begin
                    seat_st[beat.seat] = ST_THINKING;
                    r.granted_mask = try_seat(left_seat(beat.seat));
                    r.granted_mask |= try_seat(right_seat(beat.seat));
                end
            end
            OP_ADD: begin
                if (seat_cnt >= max_lim || seat_cnt >= SEATS) begin
                    r.status = STS_LIMIT;
                end else begin
                    seat_st[seat_cnt] = ST_THINKING;
                    seat_cnt++;
                end
            end
            default: begin
                if (seat_cnt <= min_lim || seat_cnt == 0) begin
                    r.status = STS_LIMIT;
                end else begin
                    seat_cnt--;
                    seat_st[seat_cnt] = ST_GONE;
                end
            end
        endcase
        for (int i = 0; i < SEATS; i++) begin
            r.eating_mask[i] = (seat_st[i] == ST_EATING);
        end
        r.active_count = seat_cnt[3:0];
        return r;
    endfunction

    function automatic void row(logic [1:0] op, logic [3:0] seat, logic typed = 1'b0,
                                logic [1:0] sts = STS_DONE, logic [8:0] g = '0,
                                logic [8:0] e = '0, logic [3:0] cnt = '0);
        t_plan_row p;
        p.beat.opcode = op;
        p.beat.seat = seat;
        p.typed = typed;
        p.res.status = sts;
        p.res.granted_mask = g;
        p.res.eating_mask = e;
        p.res.active_count = cnt;
        plan.push_back(p);
    endfunction

    function automatic t_in random_beat();
        t_in b;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) b.opcode = OP_REQUEST;
        else if (pick < 70) b.opcode = OP_RELEASE;
        else if (pick < 85) b.opcode = OP_ADD;
        else b.opcode = OP_REMOVE;
        pick = $urandom_range(0, 99);
        if (pick < 85 && seat_cnt > 0) b.seat = 4'($urandom_range(0, seat_cnt - 1));
        else if (pick < 97) b.seat = 4'($urandom_range(0, SEATS - 1));
        else b.seat = 4'($urandom_range(0, 15));
        return b;
    endfunction

    task automatic send(t_in beat, logic typed, t_out res);
        t_out want;
        while (!calm && $urandom_range(0, 99) < 10) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= beat;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want = arbitrate(beat);
        pending.push_back(typed ? res : want);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(logic idx, logic [3:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_MIN_SEATS) min_lim = val;
        else max_lim = val;
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (pending.size() != 0) @(posedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= !calm && ($urandom_range(0, 99) < 10);
    end

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending.size() == 0) begin
                $error("result beat with nothing expected: %h", o_out_data);
                n_err++;
            end else begin
                want = pending.pop_front();
                if (o_out_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status,
                           o_out_data.status);
                    n_err++;
                end
                if (o_out_data.granted_mask !== want.granted_mask) begin
                    $error("granted_mask: expected %h, actual %h", want.granted_mask,
                           o_out_data.granted_mask);
                    n_err++;
                end
                if (o_out_data.eating_mask !== want.eating_mask) begin
                    $error("eating_mask: expected %h, actual %h", want.eating_mask,
                           o_out_data.eating_mask);
                    n_err++;
                end
                if (o_out_data.active_count !== want.active_count) begin
                    $error("active_count: expected %0d, actual %0d", want.active_count,
                           o_out_data.active_count);
                    n_err++;
                end
            end
        end
    end

    initial begin
        int beats_sent;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MIN_SEATS;
        i_cfg_data = '0;
        for (int i = 0; i < SEATS; i++) seat_st[i] = ST_GONE;
        seat_cnt = 0;
        min_lim = MIN_SEATS_RST;
        max_lim = MAX_SEATS_RST;
        beats_sent = 0;

        // empty ring, then one seat that is its own neighbor
        row(OP_REQUEST, 4'd0, 1'b1, STS_INACTIVE, 9'h000, 9'h000, 4'd0);
        row(OP_RELEASE, 4'd0, 1'b1, STS_INACTIVE, 9'h000, 9'h000, 4'd0);
        row(OP_REMOVE,  4'd0, 1'b1, STS_LIMIT,    9'h000, 9'h000, 4'd0);
        row(OP_ADD,     4'd5, 1'b1, STS_DONE,     9'h000, 9'h000, 4'd1);
        row(OP_REQUEST, 4'd0, 1'b1, STS_DONE,     9'h001, 9'h001, 4'd1);
        row(OP_REQUEST, 4'd0, 1'b1, STS_BUSY,     9'h000, 9'h001, 4'd1);
        row(OP_RELEASE, 4'd0, 1'b1, STS_DONE,     9'h000, 9'h000, 4'd1);
        // two seats, then fill the ring
        row(OP_ADD, 4'd0);
        row(OP_REQUEST, 4'd1);
        row(OP_REQUEST, 4'd0);
        row(OP_RELEASE, 4'd1);
        for (int i = 0; i < 7; i++) row(OP_ADD, 4'(i));
        row(OP_ADD, 4'd15);
        // wraparound neighbors, not-eating release, remove of an eating seat
        row(OP_REQUEST, 4'd8);
        row(OP_REQUEST, 4'd15);
        row(OP_REQUEST, 4'd7);
        row(OP_RELEASE, 4'd0);
        row(OP_RELEASE, 4'd3);
        row(OP_RELEASE, 4'd7);
        row(OP_REMOVE, 4'd0);
        row(OP_RELEASE, 4'd8);
        row(OP_REQUEST, 4'd2);

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[k]) send(plan[k].beat, plan[k].typed, plan[k].res);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) begin
                i_in_valid <= 1'b0;
                drain();
                cfg_write(CFG_MIN_SEATS, lo_set[ph]);
                cfg_write(CFG_MAX_SEATS, hi_set[ph]);
                i_cfg_valid <= 1'b0;
                @(negedge i_clk);
            end
            for (int n = 0; n < PHASE_BEATS; n++) begin
                calm = (beats_sent >= 400 && beats_sent < 600);
                send(random_beat(), 1'b0, '0);
                beats_sent++;
            end
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        while (pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_err == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
